// ===== design/bles_pkg.sv =====
// ----------------------------------------------------------------------------
// bles_pkg - shared types and constants
// Field widths, register indexes and reset values of the binary Laplacian
// edge stream, plus the window column and line store entry types.
// ----------------------------------------------------------------------------
package bles_pkg;

  localparam int PIX_W      = 8;
  localparam int THR_W      = 8;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int ROW_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int MAX_HEIGHT = 4096;
  localparam int WIN_N      = 3;
  localparam int NB_CNT_W   = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_EN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_EN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd4;

  localparam logic [THR_W-1:0] THRESHOLD_RST = 8'd128;
  localparam logic [FW_W-1:0]  WIDTH_RST     = 11'd640;
  localparam logic [FH_W-1:0]  HEIGHT_RST    = 13'd480;

  localparam logic [PIX_W-1:0] PIX_SET = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_CLR = 8'h00;

  localparam logic [NB_CNT_W-1:0] NB_ALL = 4'd8;

  // one column of the 3x3 window
  typedef struct packed {
    logic top;
    logic mid;
    logic bot;
  } win_col_t;

  // one line store entry: the two rows above the incoming one
  typedef struct packed {
    logic upper;
    logic middle;
  } line_pair_t;

endpackage

// ===== design/bles_if.sv =====
// ----------------------------------------------------------------------------
// bles_if - stream channels
// Valid/ready channels for pixel items in and result items out.
// ----------------------------------------------------------------------------
interface bles_in_if;
  import bles_pkg::*;

  logic             valid;
  logic             ready;
  logic             mode;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output mode, output pixel_in, input ready);
  modport sink   (input valid, input mode, input pixel_in, output ready);
endinterface

interface bles_out_if;
  import bles_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             last_pixel;

  modport source (output valid, output pixel_out, output last_pixel, input ready);
  modport sink   (input valid, input pixel_out, input last_pixel, output ready);
endinterface

// ===== design/bles_win_cell.sv =====
// ----------------------------------------------------------------------------
// bles_win_cell - one column of the 3x3 window
// Takes the column of its right-hand neighbour on each shift.
// ----------------------------------------------------------------------------
module bles_win_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              shift_en,
  input  bles_pkg::win_col_t col_in,
  output bles_pkg::win_col_t col_out
);
  import bles_pkg::*;

  win_col_t col_r;
  win_col_t col_nxt;

  always_comb begin
    col_nxt = shift_en ? col_in : col_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      col_r <= col_nxt;
    end
  end

  assign col_out = col_r;

endmodule

// ===== design/bles_line_mem.sv =====
// ----------------------------------------------------------------------------
// bles_line_mem - line store
// One write port, one read port with registered read data (old data on a
// same-address read and write).
// ----------------------------------------------------------------------------
module bles_line_mem #(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  bles_pkg::line_pair_t wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output bles_pkg::line_pair_t rdata
);
  import bles_pkg::*;

  line_pair_t mem [DEPTH];
  line_pair_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/binary_laplacian_edge_stream.sv =====
// ----------------------------------------------------------------------------
// binary_laplacian_edge_stream - thresholded 3x3 Laplacian edge detector
// Pixels come in on in_stream in raster order (mode 0), flush items (mode 1)
// drain the tail of a completed frame. Each pixel is reduced to one bit and,
// with the filter on, a 3x3 Laplacian over in-image neighbours gives 255 on
// a nonzero sum and 0 otherwise; last_pixel marks the frame's final result.
// Registers are written on cfg_we with cfg_index/cfg_wdata; the user must
// write them only while idle, as the block itself does not enforce it.
//
// Throughput: one item per clock while the output is not stalled. An item is
// decoded and its line store entry read in the accept cycle; the window column
// cells shift and the result is registered when the decode stage fires. With
// the filter on, the causing pixel is one row plus one pixel later than the
// window centre. A stalled receiver holds the output register; in_stream.ready
// then drops once the decode stage behind it is full as well; nothing is lost.
// Synchronous reset clears counters, window and registers to their defaults;
// the line store needs no clearing, unwritten entries only reach masked
// window positions.
// ----------------------------------------------------------------------------
module binary_laplacian_edge_stream #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  bles_in_if.sink                            in_stream,
  bles_out_if.source                         out_stream,
  input  logic                               cfg_we,
  input  logic [bles_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bles_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import bles_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = (CW + 1 > FW_W) ? CW + 1 : FW_W;

  typedef struct packed {
    logic [CW-1:0]    col;
    logic [ROW_W-1:0] row;
  } pos_t;

  typedef struct packed {
    pos_t pos;
    logic wrap;
  } adv_t;

  typedef struct packed {
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
    logic last;
  } mask_t;

  typedef struct packed {
    logic             has_out;
    logic             direct;
    logic             win_upd;
    logic             mem_we;
    logic [CW-1:0]    addr;
    logic             low;
    mask_t            mask;
    logic [PIX_W-1:0] value;
  } s1_t;

  // configuration
  logic [THR_W-1:0] thr_r;
  logic             thr_en_r;
  logic             filt_en_r;
  logic [FW_W-1:0]  fw_r;
  logic [FH_W-1:0]  fh_r;

  logic [EW-1:0]    eff_w;
  logic [FH_W-1:0]  eff_h;

  pos_t in_pos_r,  in_pos_nxt;
  pos_t out_pos_r, out_pos_nxt;

  s1_t  s1_r, s1_nxt, s1_d;
  logic s1_valid_r, s1_valid_nxt;
  logic s1_load;
  logic s1_fire;
  logic accept;

  logic             pix_bit;
  logic [CW-1:0]    rd_addr;
  logic [EW-1:0]    flush_nx;

  logic       hit_r, hit_nxt;
  line_pair_t hit_data_r, hit_data_nxt;
  line_pair_t mem_rdata;
  line_pair_t rd;
  line_pair_t wr_data;
  logic       mem_we;

  win_col_t win     [WIN_N];
  win_col_t cell_in [WIN_N];
  win_col_t new_col;
  logic     win_shift;

  logic [NB_CNT_W-1:0] nb_cnt;
  logic                edge_hit;
  logic [PIX_W-1:0]    res_pix;

  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] out_pix_r, out_pix_nxt;
  logic             out_last_r, out_last_nxt;

  function automatic adv_t advance(pos_t p, logic [EW-1:0] w, logic [FH_W-1:0] h);
    adv_t a;
    a = '{pos: p, wrap: 1'b0};
    if (EW'(p.col) + EW'(1) >= w) begin
      a.pos.col = '0;
      if (FH_W'(p.row) + FH_W'(1) >= h) begin
        a.pos.row = '0;
        a.wrap    = 1'b1;
      end else begin
        a.pos.row = p.row + ROW_W'(1);
      end
    end else begin
      a.pos.col = p.col + CW'(1);
    end
    return a;
  endfunction

  function automatic mask_t edge_mask(pos_t p, logic [EW-1:0] w, logic [FH_W-1:0] h);
    mask_t m;
    m.top_ok   = (p.row != '0);
    m.bot_ok   = (FH_W'(p.row) + FH_W'(1) < h);
    m.left_ok  = (p.col != '0);
    m.right_ok = (EW'(p.col) + EW'(1) < w);
    m.last     = !m.bot_ok && !m.right_ok;
    return m;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= THRESHOLD_RST;
      thr_en_r  <= 1'b1;
      filt_en_r <= 1'b1;
      fw_r      <= WIDTH_RST;
      fh_r      <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESHOLD:    thr_r     <= cfg_wdata[THR_W-1:0];
        CFG_THRESHOLD_EN: thr_en_r  <= cfg_wdata[0];
        CFG_FILTER_EN:    filt_en_r <= cfg_wdata[0];
        CFG_FRAME_WIDTH:  fw_r      <= cfg_wdata[FW_W-1:0];
        CFG_FRAME_HEIGHT: fh_r      <= cfg_wdata[FH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (EW'(fw_r) < EW'(2)) begin
      eff_w = EW'(2);
    end else if (EW'(fw_r) > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(fw_r);
    end
    if (fh_r < FH_W'(2)) begin
      eff_h = FH_W'(2);
    end else if (fh_r > FH_W'(MAX_HEIGHT)) begin
      eff_h = FH_W'(MAX_HEIGHT);
    end else begin
      eff_h = fh_r;
    end
  end

  // handshake
  assign s1_fire = s1_valid_r && (!s1_r.has_out || !out_valid_r || out_stream.ready);
  assign in_stream.ready = !s1_valid_r || s1_fire;
  assign accept = in_stream.valid && in_stream.ready;

  // decode stage: position bookkeeping and line store read
  always_comb begin
    adv_t a_in;
    adv_t a_out;
    pos_t base;

    pix_bit  = thr_en_r ? (in_stream.pixel_in >= thr_r) : in_stream.pixel_in[0];
    flush_nx = EW'(out_pos_r.col) + EW'(1);
    s1_load  = 1'b0;
    s1_d     = '0;
    rd_addr  = in_pos_r.col;
    in_pos_nxt  = in_pos_r;
    out_pos_nxt = out_pos_r;
    a_in  = advance(in_pos_r, eff_w, eff_h);
    a_out = advance(out_pos_r, eff_w, eff_h);
    base  = ((in_pos_r.col == '0) && (in_pos_r.row == '0)) ? pos_t'('0) : out_pos_r;

    if (!filt_en_r) begin
      if (!in_stream.mode) begin
        s1_load        = 1'b1;
        s1_d.has_out   = 1'b1;
        s1_d.direct    = 1'b1;
        s1_d.mask.last = a_in.wrap;
        s1_d.value     = thr_en_r ? (pix_bit ? PIX_SET : PIX_CLR) : in_stream.pixel_in;
        in_pos_nxt     = a_in.pos;
        out_pos_nxt    = a_in.pos;
      end
    end else if (in_stream.mode) begin
      if ((in_pos_r.col == '0) && (in_pos_r.row == '0) &&
          ((out_pos_r.col != '0) || (out_pos_r.row != '0))) begin
        rd_addr      = (flush_nx >= eff_w) ? '0 : flush_nx[CW-1:0];
        s1_load      = 1'b1;
        s1_d.has_out = 1'b1;
        s1_d.win_upd = 1'b1;
        s1_d.addr    = rd_addr;
        s1_d.low     = 1'b0;
        s1_d.mask    = edge_mask(out_pos_r, eff_w, eff_h);
        out_pos_nxt  = a_out.pos;
      end
    end else begin
      s1_load      = 1'b1;
      s1_d.win_upd = 1'b1;
      s1_d.mem_we  = 1'b1;
      s1_d.addr    = in_pos_r.col;
      s1_d.low     = pix_bit;
      in_pos_nxt   = a_in.pos;
      out_pos_nxt  = base;
      if ((in_pos_r.row >= ROW_W'(2)) ||
          ((in_pos_r.row == ROW_W'(1)) && (in_pos_r.col != '0))) begin
        s1_d.has_out = 1'b1;
        s1_d.mask    = edge_mask(base, eff_w, eff_h);
        out_pos_nxt  = advance(base, eff_w, eff_h).pos;
      end
    end
  end

  always_comb begin
    s1_nxt       = (accept && s1_load) ? s1_d : s1_r;
    s1_valid_nxt = (accept && s1_load) ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
    hit_nxt      = accept ? (s1_fire && s1_r.mem_we && (s1_r.addr == rd_addr)) : hit_r;
    hit_data_nxt = accept ? wr_data : hit_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_pos_r   <= '0;
      out_pos_r  <= '0;
      s1_valid_r <= 1'b0;
      hit_r      <= 1'b0;
    end else begin
      if (accept) begin
        in_pos_r  <= in_pos_nxt;
        out_pos_r <= out_pos_nxt;
      end
      s1_valid_r <= s1_valid_nxt;
      hit_r      <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r       <= s1_nxt;
    hit_data_r <= hit_data_nxt;
  end

  // line store
  bles_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (s1_r.addr),
    .wdata (wr_data),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (mem_rdata)
  );

  // window stage
  always_comb begin
    rd        = hit_r ? hit_data_r : mem_rdata;
    new_col   = '{top: rd.upper, mid: rd.middle, bot: s1_r.low};
    wr_data   = '{upper: rd.middle, middle: s1_r.low};
    mem_we    = s1_fire && s1_r.mem_we;
    win_shift = s1_fire && s1_r.win_upd;
    cell_in[0] = win[1];
    cell_in[1] = win[2];
    cell_in[2] = new_col;
  end

  for (genvar i = 0; i < WIN_N; i++) begin : g_cell
    bles_win_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (win_shift),
      .col_in   (cell_in[i]),
      .col_out  (win[i])
    );
  end

  // evaluated on the window as it stands after this shift
  always_comb begin
    nb_cnt = NB_CNT_W'(win[1].top & s1_r.mask.top_ok & s1_r.mask.left_ok)
           + NB_CNT_W'(win[1].mid & s1_r.mask.left_ok)
           + NB_CNT_W'(win[1].bot & s1_r.mask.bot_ok & s1_r.mask.left_ok)
           + NB_CNT_W'(win[2].top & s1_r.mask.top_ok)
           + NB_CNT_W'(win[2].bot & s1_r.mask.bot_ok)
           + NB_CNT_W'(new_col.top & s1_r.mask.top_ok & s1_r.mask.right_ok)
           + NB_CNT_W'(new_col.mid & s1_r.mask.right_ok)
           + NB_CNT_W'(new_col.bot & s1_r.mask.bot_ok & s1_r.mask.right_ok);
    edge_hit = win[2].mid ? (nb_cnt != NB_ALL) : (nb_cnt != '0);
    res_pix  = s1_r.direct ? s1_r.value : (edge_hit ? PIX_SET : PIX_CLR);
  end

  // output register
  always_comb begin
    if (s1_fire && s1_r.has_out) begin
      out_valid_nxt = 1'b1;
      out_pix_nxt   = res_pix;
      out_last_nxt  = s1_r.mask.last;
    end else begin
      out_valid_nxt = out_stream.ready ? 1'b0 : out_valid_r;
      out_pix_nxt   = out_pix_r;
      out_last_nxt  = out_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pix_r  <= out_pix_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_stream.valid      = out_valid_r;
  assign out_stream.pixel_out  = out_pix_r;
  assign out_stream.last_pixel = out_last_r;

endmodule

// ===== design/bles_checker.sv =====
// ----------------------------------------------------------------------------
// bles_checker - port level checks
// Output stall behaviour, reset and the link between input and output side.
// ----------------------------------------------------------------------------
module bles_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [bles_pkg::PIX_W-1:0] pixel_out,
  input logic                      last_pixel
);
  import bles_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(pixel_out) && $stable(last_pixel))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input held off with empty output");

  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without transaction two cycles earlier");

endmodule

bind binary_laplacian_edge_stream bles_checker u_bles_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_stream.valid),
  .in_ready   (in_stream.ready),
  .out_valid  (out_stream.valid),
  .out_ready  (out_stream.ready),
  .pixel_out  (out_stream.pixel_out),
  .last_pixel (out_stream.last_pixel)
);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top - binary Laplacian edge stream testbench
// Drives pixel and flush transactions into the edge stream with random gaps,
// holds off the result side in random bursts and once for a long stretch,
// and checks every result pixel and end-of-frame flag against a bit-level
// model of thresholding, line stores, 3x3 window and raster counters.
// Covers directed corner cases, a full-width frame, resizing mid-frame,
// random frames under random settings and a final full-rate phase.
// ----------------------------------------------------------------------------
module tb_top;
  import bles_pkg::*;

  localparam int          MAX_W         = 1024;
  localparam bit          MODE_PIXEL    = 1'b0;
  localparam bit          MODE_FLUSH    = 1'b1;
  localparam int unsigned STYLE_NOISE   = 0;
  localparam int unsigned STYLE_FLAT    = 1;
  localparam int unsigned STYLE_EDGE    = 2;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_PIXELS = 1100;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             is_last;
  } edge_pix_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bles_in_if  in_ch ();
  bles_out_if out_ch ();

  binary_laplacian_edge_stream #(
    .MAX_WIDTH (MAX_W)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_ch),
    .out_stream (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // register mirror
  logic [THR_W-1:0] thr_level;
  bit               thr_on;
  bit               edge_on;
  logic [FW_W-1:0]  width_reg;
  logic [FH_W-1:0]  height_reg;

  // line stores, window and raster positions
  bit          line_upper [MAX_W];
  bit          line_middle [MAX_W];
  bit [8:0]    win3x3;
  int unsigned in_col, in_row, out_col, out_row;

  edge_pix_t   edge_pix_q[$];

  int unsigned pixel_cnt     = 0;
  int unsigned flush_cnt     = 0;
  int unsigned result_cnt    = 0;
  int unsigned frame_end_cnt = 0;
  int unsigned cfg_cnt       = 0;
  int unsigned setting_cnt   = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned quiet_cycles  = 0;
  bit          hold_req      = 1'b0;
  bit          no_idle       = 1'b0;
  bit          sender_steady = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // model
  // ---------------------------------------------------------------------------
  function automatic void reset_model();
    thr_level  = THRESHOLD_RST;
    thr_on     = 1'b1;
    edge_on    = 1'b1;
    width_reg  = WIDTH_RST;
    height_reg = HEIGHT_RST;
    foreach (line_upper[i]) begin
      line_upper[i]  = 1'b0;
      line_middle[i] = 1'b0;
    end
    win3x3  = '0;
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic int unsigned eff_width();
    int unsigned w;
    w = width_reg;
    if (w < 2) w = 2;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = height_reg;
    if (h < 2) h = 2;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  // returns 1 when the position wraps at the end of the frame
  function automatic bit raster_step(inout int unsigned col, inout int unsigned row);
    if (col + 1 >= eff_width()) begin
      col = 0;
      if (row + 1 >= eff_height()) begin
        row = 0;
        return 1'b1;
      end
      row++;
    end else begin
      col++;
    end
    return 1'b0;
  endfunction

  function automatic void shift_window(bit top, bit mid, bit low);
    win3x3 = ((win3x3 >> 1) & 9'h0DB) | {low, 2'b00, mid, 2'b00, top, 2'b00};
  endfunction

  function automatic void laplacian_emit();
    int unsigned w, h;
    int          acc;
    bit          top_ok, bot_ok, left_ok, right_ok;
    edge_pix_t   res;
    w        = eff_width();
    h        = eff_height();
    top_ok   = out_row != 0;
    bot_ok   = out_row + 1 < h;
    left_ok  = out_col != 0;
    right_ok = out_col + 1 < w;
    acc      = win3x3[4] ? 8 : 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (!(i == 1 && j == 1) && !(i == 0 && !top_ok) && !(i == 2 && !bot_ok) &&
            !(j == 0 && !left_ok) && !(j == 2 && !right_ok)) begin
          acc -= win3x3[3*i+j];
        end
      end
    end
    res.pix     = (acc != 0) ? PIX_SET : PIX_CLR;
    res.is_last = (out_row + 1 >= h) && (out_col + 1 >= w);
    edge_pix_q.push_back(res);
    void'(raster_step(out_col, out_row));
  endfunction

  function automatic void laplacian_step(bit kind, logic [PIX_W-1:0] value);
    bit          b;
    bit          emit_now;
    int unsigned x;
    edge_pix_t   res;
    b = thr_on ? (value >= thr_level) : value[0];
    if (!edge_on) begin
      if (kind == MODE_FLUSH) return;
      res.pix     = thr_on ? (b ? PIX_SET : PIX_CLR) : value;
      res.is_last = raster_step(in_col, in_row);
      edge_pix_q.push_back(res);
      out_col = in_col;
      out_row = in_row;
      return;
    end
    if (kind == MODE_FLUSH) begin
      if (in_col != 0 || in_row != 0) return;
      if (out_col == 0 && out_row == 0) return;
      x = out_col + 1;
      if (x >= eff_width()) x = 0;
      if (x >= MAX_W) x = MAX_W - 1;
      shift_window(line_upper[x], line_middle[x], 1'b0);
      laplacian_emit();
      return;
    end
    emit_now = in_row >= 2 || (in_row == 1 && in_col >= 1);
    x = (in_col < MAX_W) ? in_col : MAX_W - 1;
    if (in_col == 0 && in_row == 0) begin
      out_col = 0;
      out_row = 0;
    end
    shift_window(line_upper[x], line_middle[x], b);
    line_upper[x]  = line_middle[x];
    line_middle[x] = b;
    void'(raster_step(in_col, in_row));
    if (emit_now) laplacian_emit();
  endfunction

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned pick;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      pick = $urandom_range(0, 19);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (!no_idle && pick < 2) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (pick == 2) begin
        repeat ($urandom_range(30, 150)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    edge_pix_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (edge_pix_q.size() == 0) begin
        $display("%0t: result with none pending: expected nothing, actual pixel_out %0d last %0b",
                 $time, out_ch.pixel_out, out_ch.last_pixel);
        mismatch_cnt++;
      end else begin
        want = edge_pix_q.pop_front();
        if (out_ch.pixel_out !== want.pix) begin
          $display("%0t: pixel_out expected %0d actual %0d", $time, want.pix, out_ch.pixel_out);
          mismatch_cnt++;
        end
        if (out_ch.last_pixel !== want.is_last) begin
          $display("%0t: last_pixel expected %0b actual %0b",
                   $time, want.is_last, out_ch.last_pixel);
          mismatch_cnt++;
        end
        result_cnt++;
        if (want.is_last) frame_end_cnt++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers, all entered on a rising edge
  // ---------------------------------------------------------------------------
  task automatic stream_item(input bit kind, input logic [PIX_W-1:0] value);
    if (!no_idle && !sender_steady && $urandom_range(0, 15) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= kind;
    in_ch.pixel_in <= value;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    laplacian_step(kind, value);
    if (kind == MODE_FLUSH) flush_cnt++;
    else pixel_cnt++;
  endtask

  task automatic drain_block();
    in_ch.valid <= 1'b0;
    while (edge_pix_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_THRESHOLD:    thr_level  = val[THR_W-1:0];
      CFG_THRESHOLD_EN: thr_on     = val[0];
      CFG_FILTER_EN:    edge_on    = val[0];
      CFG_FRAME_WIDTH:  width_reg  = val[FW_W-1:0];
      CFG_FRAME_HEIGHT: height_reg = val[FH_W-1:0];
      default: ;
    endcase
    cfg_cnt++;
    @(posedge clk);
  endtask

  function automatic logic [PIX_W-1:0] gen_pixel(int unsigned style, int unsigned base);
    int v;
    case (style)
      STYLE_NOISE: return PIX_W'($urandom_range(0, 255));
      STYLE_FLAT:  return ($urandom_range(0, 7) == 0) ? PIX_W'($urandom_range(0, 255))
                                                      : PIX_W'(base);
      default: begin
        v = int'(thr_level) + int'($urandom_range(0, 2)) - 1;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return PIX_W'(v);
      end
    endcase
  endfunction

  // pixels up to the end of the current frame, stray flushes among them,
  // then a full or partial drain of the tail
  task automatic stream_frame(input bit full_drain);
    int unsigned style, base, n_flush;
    style = $urandom_range(STYLE_NOISE, STYLE_EDGE);
    base  = $urandom_range(0, 255);
    do begin
      if ($urandom_range(0, 29) == 0) stream_item(MODE_FLUSH, PIX_W'($urandom));
      stream_item(MODE_PIXEL, gen_pixel(style, base));
    end while (in_col != 0 || in_row != 0);
    if (!edge_on) n_flush = $urandom_range(0, 2);
    else if (full_drain || $urandom_range(0, 5) != 0) n_flush = eff_width() + 1;
    else n_flush = $urandom_range(0, eff_width() + 2);
    repeat (n_flush) stream_item(MODE_FLUSH, PIX_W'($urandom));
  endtask

  task automatic random_setup();
    int unsigned t, w, h;
    case ($urandom_range(0, 5))
      0:       t = 0;
      1:       t = 255;
      2:       t = 1;
      3:       t = 254;
      default: t = $urandom_range(0, 255);
    endcase
    case ($urandom_range(0, 9))
      0:       w = $urandom_range(0, 1);
      1, 2:    w = $urandom_range(9, 40);
      default: w = $urandom_range(2, 8);
    endcase
    h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 5);
    drain_block();
    write_reg(CFG_THRESHOLD, t);
    write_reg(CFG_THRESHOLD_EN, $urandom_range(0, 1));
    write_reg(CFG_FILTER_EN, ($urandom_range(0, 4) != 0));
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    setting_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    drain_block();
    write_reg(CFG_FRAME_WIDTH, 2);
    write_reg(CFG_FRAME_HEIGHT, 2);
    stream_item(MODE_FLUSH, 8'hFF);   // nothing pending
    stream_item(MODE_PIXEL, 8'd255);
    stream_item(MODE_FLUSH, 8'h00);   // mid-frame, ignored
    stream_item(MODE_PIXEL, 8'd128);  // exactly at threshold
    stream_item(MODE_PIXEL, 8'd127);
    stream_item(MODE_PIXEL, 8'd0);
    repeat (2) stream_item(MODE_FLUSH, 8'h00);
    // new frame with one result still undrained
    stream_item(MODE_PIXEL, 8'd200);
    stream_item(MODE_PIXEL, 8'd0);
    stream_item(MODE_PIXEL, 8'd255);
    stream_item(MODE_PIXEL, 8'd128);
    repeat (4) stream_item(MODE_FLUSH, 8'h5A);
    drain_block();
    // filter off; sizes below range saturate to 2x2
    write_reg(CFG_FILTER_EN, 0);
    write_reg(CFG_FRAME_WIDTH, 1);
    write_reg(CFG_FRAME_HEIGHT, 0);
    stream_item(MODE_FLUSH, 8'hA5);
    stream_item(MODE_PIXEL, 8'd127);
    stream_item(MODE_PIXEL, 8'd128);
    drain_block();
    write_reg(CFG_THRESHOLD_EN, 0);
    stream_item(MODE_PIXEL, 8'd254);
    stream_item(MODE_PIXEL, 8'd255);
  endtask

  task automatic test_wide_frame();
    drain_block();
    write_reg(CFG_THRESHOLD, 128);
    write_reg(CFG_THRESHOLD_EN, 1);
    write_reg(CFG_FILTER_EN, 1);
    write_reg(CFG_FRAME_WIDTH, 2047);   // saturates to the line store size
    write_reg(CFG_FRAME_HEIGHT, 1);
    stream_frame(1'b1);
  endtask

  task automatic test_resize_midframe();
    drain_block();
    write_reg(CFG_THRESHOLD, 100);
    write_reg(CFG_FRAME_WIDTH, 6);
    write_reg(CFG_FRAME_HEIGHT, 4);
    repeat (15) stream_item(MODE_PIXEL, gen_pixel(STYLE_NOISE, 0));
    drain_block();
    write_reg(CFG_FRAME_WIDTH, 3);      // column now beyond the row end
    repeat (4) stream_item(MODE_PIXEL, gen_pixel(STYLE_NOISE, 0));
    drain_block();
    write_reg(CFG_FRAME_HEIGHT, 8191);
    write_reg(CFG_FRAME_WIDTH, 5);
    repeat (7) stream_item(MODE_PIXEL, gen_pixel(STYLE_EDGE, 0));
    drain_block();
    write_reg(CFG_FILTER_EN, 0);
    repeat (3) stream_item(MODE_PIXEL, gen_pixel(STYLE_NOISE, 0));
    drain_block();
    write_reg(CFG_FILTER_EN, 1);
    repeat (3) stream_item(MODE_PIXEL, gen_pixel(STYLE_NOISE, 0));
    drain_block();
    write_reg(CFG_FRAME_HEIGHT, 3);
    write_reg(CFG_FRAME_WIDTH, 4);
    stream_frame(1'b1);
    setting_cnt += 5;
  endtask

  task automatic test_random_frames();
    int unsigned start;
    start = pixel_cnt;
    while (pixel_cnt - start < RANDOM_PIXELS) begin
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 6)) stream_item(MODE_PIXEL, gen_pixel(STYLE_NOISE, 0));
      end
      random_setup();
      repeat ($urandom_range(1, 4)) stream_frame(1'b0);
    end
  endtask

  task automatic test_backpressure();
    drain_block();
    write_reg(CFG_FILTER_EN, 1);
    write_reg(CFG_THRESHOLD_EN, 1);
    write_reg(CFG_FRAME_WIDTH, 8);
    write_reg(CFG_FRAME_HEIGHT, 4);
    sender_steady = 1'b1;
    hold_req      = 1'b1;
    repeat (2) stream_frame(1'b1);
    sender_steady = 1'b0;
    setting_cnt++;
  endtask

  task automatic test_full_rate();
    drain_block();
    no_idle = 1'b1;
    write_reg(CFG_THRESHOLD_EN, 0);
    write_reg(CFG_FRAME_WIDTH, 5);
    write_reg(CFG_FRAME_HEIGHT, 3);
    repeat (8) stream_frame(1'b1);
    drain_block();
    write_reg(CFG_FILTER_EN, 0);
    write_reg(CFG_THRESHOLD_EN, 1);
    write_reg(CFG_THRESHOLD, $urandom_range(1, 254));
    repeat (3) stream_frame(1'b1);
    setting_cnt += 2;
  endtask

  initial begin
    in_ch.valid    <= 1'b0;
    in_ch.mode     <= MODE_PIXEL;
    in_ch.pixel_in <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_THRESHOLD;
    cfg_wdata      <= '0;
    rst_n          <= 1'b0;
    reset_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_wide_frame();
    test_resize_midframe();
    test_random_frames();
    test_backpressure();
    test_full_rate();
    drain_block();

    $display("Covered %0d pixel and %0d flush transactions; %0d results checked, %0d frame ends.",
             pixel_cnt, flush_cnt, result_cnt, frame_end_cnt);
    $display("%0d register writes over %0d settings; %0d mismatches.",
             cfg_cnt, setting_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
